[hw/rtl/bsb_pkg.sv]
// Shared control type, constants and helper function for the B-spline to Bezier converter.
package bsb_pkg;

  localparam int AXES = 3;
  // Radix-4 quotient digits resolved per stage of the divide-by-three pipeline.
  localparam int DIGITS_PER_STAGE = 4;

  typedef struct packed {
    logic adv;        // whole datapath advances this cycle
    logic take;       // an input transaction is accepted
    logic take_last;  // the accepted point closes its curve
    logic bstore;     // head item updates the stored two-thirds point
    logic bclear;     // head item clears the stored two-thirds point
  } bsb_ctl_t;

  // One radix-4 step of division by three: returns {quotient digit, new remainder}.
  function automatic logic [3:0] div3_digit(input logic [1:0] rem, input logic [1:0] dig);
    logic [3:0] t;
    logic [1:0] qd;
    logic [3:0] r;
    t = {rem, dig};
    if (t >= 4'd9) begin
      qd = 2'd3;
    end else if (t >= 4'd6) begin
      qd = 2'd2;
    end else if (t >= 4'd3) begin
      qd = 2'd1;
    end else begin
      qd = 2'd0;
    end
    r = t - ({2'b00, qd} + {1'b0, qd, 1'b0});
    return {qd, r[1:0]};
  endfunction

endpackage

[hw/rtl/bsb_div3.sv]
// Pipelined radix-4 floor division of an unsigned word by three.
module bsb_div3 #(
  parameter int UW = 34
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [UW-1:0] u_i,
  output logic [UW-1:0] quo_o,
  output logic [1:0]    rem_o
);
  import bsb_pkg::*;

  localparam int ND = UW / 2;
  localparam int NS = (ND + DIGITS_PER_STAGE - 1) / DIGITS_PER_STAGE;

  logic [UW-1:0] u_q [NS];
  logic [UW-1:0] q_q [NS];
  logic [1:0]    r_q [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [UW-1:0] u_in;
    logic [UW-1:0] q_in;
    logic [1:0]    r_in;
    logic [UW-1:0] q_nx;
    logic [1:0]    r_nx;

    if (s == 0) begin : g_first
      assign u_in = u_i;
      assign q_in = '0;
      assign r_in = '0;
    end else begin : g_next
      assign u_in = u_q[s-1];
      assign q_in = q_q[s-1];
      assign r_in = r_q[s-1];
    end

    // Digits are taken from the most significant end; the remainder ripples down.
    always_comb begin
      int idx;
      logic [3:0] st;
      q_nx = q_in;
      r_nx = r_in;
      st   = '0;
      for (int k = 0; k < DIGITS_PER_STAGE; k++) begin
        idx = ND - 1 - (s * DIGITS_PER_STAGE + k);
        if (idx >= 0) begin
          st = div3_digit(r_nx, u_in[2*idx +: 2]);
          q_nx[2*idx +: 2] = st[3:2];
          r_nx = st[1:0];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        u_q[s] <= u_in;
        q_q[s] <= q_nx;
        r_q[s] <= r_nx;
      end
    end
  end

  assign quo_o = q_q[NS-1];
  assign rem_o = r_q[NS-1];

endmodule

[hw/rtl/bsb_lane.sv]
// One coordinate lane: third points, two-thirds point history and junction point.
module bsb_lane #(
  parameter int W = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  bsb_pkg::bsb_ctl_t       ctl_i,
  input  logic signed [W-1:0]     coord_i,
  output logic signed [W-1:0]     jn_o,
  output logic signed [W-1:0]     a_o,
  output logic signed [W-1:0]     b_o
);
  import bsb_pkg::*;

  localparam int UW = 2 * ((W + 3) / 2);
  localparam int ND = UW / 2;
  localparam int NS = (ND + DIGITS_PER_STAGE - 1) / DIGITS_PER_STAGE;

  logic [W-1:0]  p_q;
  logic [W:0]    diff;
  logic [UW-1:0] u;
  logic [UW-1:0] quo;
  logic [1:0]    rem;
  logic [W-1:0]  pd_q [NS];
  logic [W-1:0]  qd_q [NS];
  logic [W:0]    third;
  logic [W:0]    a_n;
  logic [W:0]    b_n;
  logic [W-1:0]  a_q;
  logic [W-1:0]  b_q;
  logic [W-1:0]  bp_q;
  logic [W:0]    jsum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q <= '0;
    end else if (ctl_i.take) begin
      p_q <= ctl_i.take_last ? '0 : coord_i;
    end
  end

  // With d = Q - P: (2P+Q)/3 = P + d/3 and (P+2Q)/3 = Q - ceil(d/3).
  // The offset 3*2^W makes the dividend nonnegative and adds exactly 2^W to the quotient.
  assign diff = {coord_i[W-1], coord_i} - {p_q[W-1], p_q};
  assign u    = {{(UW-W-1){diff[W]}}, diff} + (UW'(3) << W);

  bsb_div3 #(
    .UW (UW)
  ) u_div (
    .clk_i (clk_i),
    .en_i  (ctl_i.adv),
    .u_i   (u),
    .quo_o (quo),
    .rem_o (rem)
  );

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      pd_q[0] <= p_q;
      qd_q[0] <= coord_i;
      for (int k = 1; k < NS; k++) begin
        pd_q[k] <= pd_q[k-1];
        qd_q[k] <= qd_q[k-1];
      end
    end
  end

  assign third = quo[W:0] ^ ((W+1)'(1) << W);
  assign a_n   = {pd_q[NS-1][W-1], pd_q[NS-1]} + third;
  assign b_n   = {qd_q[NS-1][W-1], qd_q[NS-1]} - third - (W+1)'(rem != 2'd0);

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      a_q <= a_n[W-1:0];
      b_q <= b_n[W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bp_q <= '0;
    end else if (ctl_i.bclear) begin
      bp_q <= '0;
    end else if (ctl_i.bstore) begin
      bp_q <= b_q;
    end
  end

  assign jsum = {bp_q[W-1], bp_q} + {a_q[W-1], a_q};
  assign jn_o = jsum[W:1];
  assign a_o  = a_q;
  assign b_o  = b_q;

endmodule

[hw/rtl/bsb_emit.sv]
// Merges lane results into control points, sent one per cycle unless stalled.
module bsb_emit #(
  parameter int W = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    load_i,
  input  logic                    three_i,
  input  logic [W-1:0]            jn_i [bsb_pkg::AXES],
  input  logic [W-1:0]            a_i  [bsb_pkg::AXES],
  input  logic [W-1:0]            b_i  [bsb_pkg::AXES],
  input  logic                    tready_i,
  output logic                    tvalid_o,
  output logic [((bsb_pkg::AXES*W+7)/8)*8-1:0] tdata_o,
  output logic                    tlast_o,
  output logic                    free_o
);
  import bsb_pkg::*;

  localparam int PW  = AXES * W;
  localparam int TDW = ((AXES * W + 7) / 8) * 8;

  logic [PW-1:0] jn_pt;
  logic [PW-1:0] a_pt;
  logic [PW-1:0] b_pt;
  logic [PW-1:0] slot_q [3];
  logic [1:0]    left_q;
  logic          fire;

  always_comb begin
    for (int j = 0; j < AXES; j++) begin
      jn_pt[j*W +: W] = jn_i[j];
      a_pt[j*W +: W]  = a_i[j];
      b_pt[j*W +: W]  = b_i[j];
    end
  end

  assign fire     = tvalid_o && tready_i;
  assign tvalid_o = (left_q != 2'd0);
  assign tlast_o  = (left_q == 2'd1);
  assign tdata_o  = TDW'(slot_q[0]);
  // A new item may load while the final result of the current one leaves.
  assign free_o   = (left_q == 2'd0) || (left_q == 2'd1 && tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= 2'd0;
    end else if (load_i) begin
      left_q <= three_i ? 2'd3 : 2'd1;
    end else if (fire) begin
      left_q <= left_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      slot_q[0] <= jn_pt;
      slot_q[1] <= a_pt;
      slot_q[2] <= b_pt;
    end else if (fire) begin
      slot_q[0] <= slot_q[1];
      slot_q[1] <= slot_q[2];
    end
  end

endmodule

[hw/rtl/bspline_to_bezier_points.sv]
// Top level of the uniform cubic B-spline to Bezier control point converter.
//
//   channel   dir  payload (tdata from bit 0 up)            tlast
//   s_axis    in   in_x, in_y, in_z (COORD_WIDTH each)      in_last
//   m_axis    out  out_x, out_y, out_z (COORD_WIDTH each)   run_end
//
// One de Boor point can be accepted every cycle while the pipeline advances; a point
// with three results holds the output queue until its last result leaves.
// Each lane holds NS = ceil(ceil((W+2)/2)/4) stages of the radix-4 divide-by-three
// pipeline (NS = 5 at W = 32). Reset clears the point history, the point count and
// the output queue at once. A stalled output channel stops the whole pipeline once
// the item at its head has results, and s_axis_tready_o drops with it.
module bspline_to_bezier_points #(
  parameter int COORD_WIDTH = 32,
  localparam int TDW = ((bsb_pkg::AXES * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid_i,
  output logic           s_axis_tready_o,
  input  logic [TDW-1:0] s_axis_tdata_i,   // in_x, in_y, in_z
  input  logic           s_axis_tlast_i,   // in_last
  output logic           m_axis_tvalid_o,
  input  logic           m_axis_tready_i,
  output logic [TDW-1:0] m_axis_tdata_o,   // out_x, out_y, out_z
  output logic           m_axis_tlast_o    // run_end
);
  import bsb_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int UW = 2 * ((W + 3) / 2);
  localparam int ND = UW / 2;
  localparam int NS = (ND + DIGITS_PER_STAGE - 1) / DIGITS_PER_STAGE;

  bsb_ctl_t   ctl;
  logic [1:0] cnt_in_q;
  logic       vld_q  [NS+1];
  logic [1:0] cnt_q  [NS+1];
  logic       last_q [NS+1];
  logic       head_three;
  logic       head_one;
  logic       emit_free;
  logic [W-1:0] jn [AXES];
  logic [W-1:0] a  [AXES];
  logic [W-1:0] b  [AXES];

  // Result count of the item at the head: three in mid-curve, one on a long curve's end.
  assign head_three = !last_q[NS] && (cnt_q[NS] >= 2'd2);
  assign head_one   = last_q[NS] && (cnt_q[NS] == 2'd3);

  always_comb begin
    ctl.adv       = !vld_q[NS] || !(head_three || head_one) || emit_free;
    ctl.take      = s_axis_tvalid_i && ctl.adv;
    ctl.take_last = s_axis_tlast_i;
    ctl.bstore    = ctl.adv && vld_q[NS] && !last_q[NS] && (cnt_q[NS] != 2'd0);
    ctl.bclear    = ctl.adv && vld_q[NS] && last_q[NS];
  end

  assign s_axis_tready_o = ctl.adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_in_q <= 2'd0;
    end else if (ctl.take) begin
      if (s_axis_tlast_i) begin
        cnt_in_q <= 2'd0;
      end else if (cnt_in_q != 2'd3) begin
        cnt_in_q <= cnt_in_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= NS; k++) begin
        vld_q[k]  <= 1'b0;
        cnt_q[k]  <= 2'd0;
        last_q[k] <= 1'b0;
      end
    end else if (ctl.adv) begin
      vld_q[0]  <= ctl.take;
      cnt_q[0]  <= cnt_in_q;
      last_q[0] <= s_axis_tlast_i;
      for (int k = 1; k <= NS; k++) begin
        vld_q[k]  <= vld_q[k-1];
        cnt_q[k]  <= cnt_q[k-1];
        last_q[k] <= last_q[k-1];
      end
    end
  end

  for (genvar j = 0; j < AXES; j++) begin : g_lane
    bsb_lane #(
      .W (W)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .coord_i (s_axis_tdata_i[j*W +: W]),
      .jn_o    (jn[j]),
      .a_o     (a[j]),
      .b_o     (b[j])
    );
  end

  bsb_emit #(
    .W (W)
  ) u_emit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (ctl.adv && vld_q[NS] && (head_three || head_one)),
    .three_i  (head_three),
    .jn_i     (jn),
    .a_i      (a),
    .b_i      (b),
    .tready_i (m_axis_tready_i),
    .tvalid_o (m_axis_tvalid_o),
    .tdata_o  (m_axis_tdata_o),
    .tlast_o  (m_axis_tlast_o),
    .free_o   (emit_free)
  );

endmodule

[hw/rtl/bsb_checker.sv]
// Port-level assertions for the converter and the bind that attaches them.
module bsb_checker #(
  parameter int COORD_WIDTH = 32,
  localparam int TDW = ((bsb_pkg::AXES * COORD_WIDTH + 7) / 8) * 8
) (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           s_tvalid_i,
  input logic           s_tready_i,
  input logic           m_tvalid_i,
  input logic           m_tready_i,
  input logic [TDW-1:0] m_tdata_i,
  input logic           m_tlast_i
);

  logic [1:0] seen_q;

  // Results of the current input point delivered so far.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 2'd0;
    end else if (m_tvalid_i && m_tready_i) begin
      seen_q <= m_tlast_i ? 2'd0 : seen_q + 2'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i) && $stable(m_tlast_i))
    else $error("stalled result transaction changed");

  a_third_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && seen_q == 2'd2 |-> m_tlast_i)
    else $error("more than three results for one input point");

  a_group_gapless: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && m_tready_i && !m_tlast_i |=> m_tvalid_i)
    else $error("gap inside the results of one input point");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && !m_tvalid_i |-> s_tready_i)
    else $error("input stalled while the output queue is empty");

endmodule

bind bspline_to_bezier_points bsb_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_bsb_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid_i),
  .s_tready_i (s_axis_tready_o),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o),
  .m_tlast_i  (m_axis_tlast_o)
);
